/* hw/rtl/htfc_pkg.sv */
// Shared constants, types and CRC helper for the humidity/temperature frame checker.
// No dependencies.
`default_nettype none

package htfc_pkg;

    localparam int CNT_BITS = 32;          // width of the good/bad word counters
    localparam int TOTAL_BITS = 32;        // width of the counter totals on the port

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [16:0] FULL_SCALE = 17'd65535;
    localparam logic [14:0] TEMP_SPAN = 15'd17500;
    localparam logic [14:0] HUM_SPAN = 15'd10000;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

    localparam int IN_BITS = 48;
    localparam int OUT_BITS = 192;

    // One lane's finding for one word
    typedef struct packed {
        logic        ok;
        logic [14:0] quot;
    } lane_res_t;

    // CRC-8, MSB first, one byte folded into the running value
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Low TOTAL_BITS of a counter, zero extended where the counter is narrower
    function automatic logic [TOTAL_BITS-1:0] cnt_total(input logic [CNT_BITS-1:0] cnt);
        logic [63:0] w;
        w = 64'(cnt);
        return w[TOTAL_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/htfc_lane.sv */
// One word lane: CRC-8 check and scaling floor(span*raw/65535).
// Depends on htfc_pkg.
`default_nettype none

module htfc_lane (
    input  wire logic                clk,
    input  wire logic                load,
    input  wire logic [7:0]          word_high,
    input  wire logic [7:0]          word_low,
    input  wire logic [7:0]          check,
    input  wire logic [14:0]         span,
    output htfc_pkg::lane_res_t      res
);
    import htfc_pkg::*;

    logic [7:0]  crc_part_reg;
    logic [7:0]  low_reg;
    logic [7:0]  check_reg;
    logic [30:0] prod_reg;

    logic [7:0]  crc_full;
    logic [14:0] q_coarse;
    logic [16:0] rem;

    // first stage: high byte through the CRC, product of span and raw word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            crc_part_reg <= crc8_byte(CRC_INIT, word_high);
            low_reg      <= word_low;
            check_reg    <= check;
            prod_reg     <= 31'(span) * 31'({word_high, word_low});
        end
    end

    // x/65535: take x>>16, remainder is low half plus that quotient, one correction
    always_comb
    begin
        crc_full = crc8_byte(crc_part_reg, low_reg);
        q_coarse = prod_reg[30:16];
        rem      = 17'(prod_reg[15:0]) + 17'(q_coarse);
        res.ok   = (crc_full == check_reg);
        res.quot = q_coarse + 15'((rem >= FULL_SCALE) ? 1'b1 : 1'b0);
    end

endmodule

`default_nettype wire

/* hw/rtl/htfc_merge.sv */
// Merging stage: combines the two lanes into result fields, counters and held readings.
// Depends on htfc_pkg.
`default_nettype none

module htfc_merge (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire htfc_pkg::lane_res_t         temp_res,
    input  wire htfc_pkg::lane_res_t         hum_res,
    output logic signed [14:0]               temp_centi,
    output logic [13:0]                      hum_centi,
    output logic                             frame_failed,
    output logic signed [14:0]               held_temp,
    output logic [13:0]                      held_hum,
    output logic [htfc_pkg::TOTAL_BITS-1:0]  temp_good_total,
    output logic [htfc_pkg::TOTAL_BITS-1:0]  temp_bad_total,
    output logic [htfc_pkg::TOTAL_BITS-1:0]  hum_good_total,
    output logic [htfc_pkg::TOTAL_BITS-1:0]  hum_bad_total
);
    import htfc_pkg::*;

    logic signed [14:0]  temp_reg, temp_next;
    logic [13:0]         hum_reg, hum_next;
    logic                failed_reg, failed_next;
    logic signed [14:0]  last_temp_reg, last_temp_next;
    logic [13:0]         last_hum_reg, last_hum_next;
    logic [CNT_BITS-1:0] temp_good_reg, temp_good_next;
    logic [CNT_BITS-1:0] temp_bad_reg, temp_bad_next;
    logic [CNT_BITS-1:0] hum_good_reg, hum_good_next;
    logic [CNT_BITS-1:0] hum_bad_reg, hum_bad_next;
    logic signed [15:0]  temp_wide;

    always_comb
    begin
        temp_wide      = $signed({1'b0, temp_res.quot}) - TEMP_OFFSET;
        temp_next      = 15'sd0;
        hum_next       = 14'd0;
        failed_next    = !(temp_res.ok && hum_res.ok);
        last_temp_next = last_temp_reg;
        last_hum_next  = last_hum_reg;
        temp_good_next = temp_good_reg;
        temp_bad_next  = temp_bad_reg;
        hum_good_next  = hum_good_reg;
        hum_bad_next   = hum_bad_reg;
        if (temp_res.ok)
        begin
            temp_next      = temp_wide[14:0];
            last_temp_next = temp_wide[14:0];
            temp_good_next = temp_good_reg + CNT_BITS'(1);
        end
        else
        begin
            temp_bad_next = temp_bad_reg + CNT_BITS'(1);
        end
        if (hum_res.ok)
        begin
            hum_next       = hum_res.quot[13:0];
            last_hum_next  = hum_res.quot[13:0];
            hum_good_next  = hum_good_reg + CNT_BITS'(1);
        end
        else
        begin
            hum_bad_next = hum_bad_reg + CNT_BITS'(1);
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            failed_reg <= failed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_temp_reg <= '0;
            last_hum_reg  <= '0;
            temp_good_reg <= '0;
            temp_bad_reg  <= '0;
            hum_good_reg  <= '0;
            hum_bad_reg   <= '0;
        end
        else if (load)
        begin
            last_temp_reg <= last_temp_next;
            last_hum_reg  <= last_hum_next;
            temp_good_reg <= temp_good_next;
            temp_bad_reg  <= temp_bad_next;
            hum_good_reg  <= hum_good_next;
            hum_bad_reg   <= hum_bad_next;
        end
    end

    // state only moves with the output register, so it doubles as the result fields
    assign temp_centi      = temp_reg;
    assign hum_centi       = hum_reg;
    assign frame_failed    = failed_reg;
    assign held_temp       = last_temp_reg;
    assign held_hum        = last_hum_reg;
    assign temp_good_total = cnt_total(temp_good_reg);
    assign temp_bad_total  = cnt_total(temp_bad_reg);
    assign hum_good_total  = cnt_total(hum_good_reg);
    assign hum_bad_total   = cnt_total(hum_bad_reg);

endmodule

`default_nettype wire

/* hw/rtl/humidity_temp_frame_checker_core.sv */
// Humidity/temperature readout frame checker: top level, two word lanes and a merging stage.
// Depends on htfc_pkg, htfc_lane, htfc_merge.
//
// Usage:
//   s_* takes one six-byte readout frame per transaction (tvalid & tready).
//   m_* returns one result per frame: both converted words (0 where the CRC
//   failed), the fail flag, the held last good readings and the four word
//   counters as they stand after that frame.
//   m_tvalid rises once a frame has passed the lane register and then the output register.
//   One frame per cycle is sustained while m_tready is high; the rate is set by the
//   two-stage pipeline (lane register for CRC first byte and span multiply, then output
//   register after the divide-by-65535 correction and counter update).
//   When the receiver stalls, the output register holds its result and the
//   lane stage may still take one more frame; s_tready drops only when both
//   stages are full.
//   Reset clears both valid flags, the counters and the held readings;
//   the first result after reset counts from zero.
`default_nettype none

module humidity_temp_frame_checker_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [7:0] temp_high, [15:8] temp_low, [23:16] temp_check,
    // [31:24] hum_high, [39:32] hum_low, [47:40] hum_check
    input  wire logic [htfc_pkg::IN_BITS-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [14:0] temp_centi, [28:15] hum_centi, [29] frame_failed, [44:30] held_temp,
    // [58:45] held_hum, [90:59] temp_good_total, [122:91] temp_bad_total,
    // [154:123] hum_good_total, [186:155] hum_bad_total, [191:187] zero
    output logic [htfc_pkg::OUT_BITS-1:0]      m_tdata
);
    import htfc_pkg::*;

    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s_take, out_load;

    lane_res_t temp_res, hum_res;

    logic signed [14:0]    temp_centi, held_temp;
    logic [13:0]           hum_centi, held_hum;
    logic                  frame_failed;
    logic [TOTAL_BITS-1:0] temp_good_total, temp_bad_total, hum_good_total, hum_bad_total;

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || out_load;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            s1_valid_next  = 1'b0;
        end
        if (s_take)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    htfc_lane u_temp_lane (
        .clk       (clk),
        .load      (s_take),
        .word_high (s_tdata[7:0]),
        .word_low  (s_tdata[15:8]),
        .check     (s_tdata[23:16]),
        .span      (TEMP_SPAN),
        .res       (temp_res)
    );

    htfc_lane u_hum_lane (
        .clk       (clk),
        .load      (s_take),
        .word_high (s_tdata[31:24]),
        .word_low  (s_tdata[39:32]),
        .check     (s_tdata[47:40]),
        .span      (HUM_SPAN),
        .res       (hum_res)
    );

    htfc_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (out_load),
        .temp_res        (temp_res),
        .hum_res         (hum_res),
        .temp_centi      (temp_centi),
        .hum_centi       (hum_centi),
        .frame_failed    (frame_failed),
        .held_temp       (held_temp),
        .held_hum        (held_hum),
        .temp_good_total (temp_good_total),
        .temp_bad_total  (temp_bad_total),
        .hum_good_total  (hum_good_total),
        .hum_bad_total   (hum_bad_total)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, hum_bad_total, hum_good_total, temp_bad_total, temp_good_total,
                       held_hum, held_temp, frame_failed, hum_centi, temp_centi};

endmodule

`default_nettype wire
